// File: rtl/adb_pkg.sv
// ----------------------------------------------------------------------------
// adb_pkg
// Shared types and constants for the ADB message deframer.
// ----------------------------------------------------------------------------
package adb_pkg;

    localparam int unsigned MAX_PAYLOAD = 4096;
    localparam int unsigned CAP_W       = 13;
    localparam int unsigned SLICE_W     = 16;
    localparam int unsigned WORD_W      = 32;
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned FUNC_W      = 2;
    localparam int unsigned STATUS_W    = 3;
    localparam int unsigned HDR_WORDS   = 6;
    localparam int unsigned HDR_BYTES   = 24;
    localparam int unsigned HCOUNT_W    = 5;
    localparam int unsigned CFG_INDEX_W = 1;
    localparam int unsigned CFG_DATA_W  = 16;

    localparam logic [CAP_W-1:0]   CAP_RESET     = CAP_W'(4096);
    localparam logic [SLICE_W-1:0] TIMEOUT_RESET = SLICE_W'(600);
    localparam logic [CAP_W-1:0]   CAP_LIMIT     = CAP_W'(MAX_PAYLOAD);

    typedef enum logic [FUNC_W-1:0] {
        FN_BYTE  = 2'd0,
        FN_TICK  = 2'd1,
        FN_CLOSE = 2'd2
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_BAD_MAGIC = 3'd1,
        ST_TOO_LONG  = 3'd2,
        ST_BAD_SUM   = 3'd3,
        ST_TIMEOUT   = 3'd4,
        ST_CLOSED    = 3'd5
    } status_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_CAPACITY = 1'd0,
        REG_TIMEOUT  = 1'd1
    } cfg_reg_t;

    typedef struct packed {
        logic    go_payload;
        status_t status;
    } hdr_result_t;

endpackage

// File: rtl/adb_hdr_check.sv
// ----------------------------------------------------------------------------
// adb_hdr_check
// Verdict on a completed header: magic, length against capacity, empty payload.
// ----------------------------------------------------------------------------
module adb_hdr_check (
    input  logic [adb_pkg::WORD_W-1:0] command,
    input  logic [adb_pkg::WORD_W-1:0] length,
    input  logic [adb_pkg::WORD_W-1:0] check,
    input  logic [adb_pkg::WORD_W-1:0] magic,
    input  logic [adb_pkg::CAP_W-1:0]  capacity,
    output adb_pkg::hdr_result_t       result
);
    import adb_pkg::*;

    logic [CAP_W-1:0] cap_eff;

    assign cap_eff = (capacity > CAP_LIMIT) ? CAP_LIMIT : capacity;

    always_comb
    begin
        result.go_payload = 1'b0;
        result.status     = ST_OK;
        priority if (magic != ~command)
        begin
            result.status = ST_BAD_MAGIC;
        end
        else if (length > {{(WORD_W-CAP_W){1'b0}}, cap_eff})
        begin
            result.status = ST_TOO_LONG;
        end
        else if (length == '0)
        begin
            result.status = (check == '0) ? ST_OK : ST_BAD_SUM;
        end
        else
        begin
            result.go_payload = 1'b1;
        end
    end

endmodule

// File: rtl/adb_message_deframer_unit.sv
// ----------------------------------------------------------------------------
// adb_message_deframer_unit
// Header assembly, payload pass-through with byte sum, and message verdicts.
// ----------------------------------------------------------------------------
// One link event is taken per clock cycle. Its result, if any, appears in the
// output register on the following cycle; in_ready drops only while that
// register holds a transaction the consumer has not taken, so a stream of
// events runs at one per cycle whenever out_ready stays high. All work for an
// event is one register-to-register step: a byte-lane write, a 32-bit add and
// compare, or the header verdict.
module adb_message_deframer_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [adb_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [adb_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [adb_pkg::FUNC_W-1:0]   func,
    input  logic [adb_pkg::BYTE_W-1:0]   rx_byte,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         kind,
    output logic [adb_pkg::BYTE_W-1:0]   data_byte,
    output logic [adb_pkg::WORD_W-1:0]   command,
    output logic [adb_pkg::WORD_W-1:0]   arg_first,
    output logic [adb_pkg::WORD_W-1:0]   arg_second,
    output logic [adb_pkg::WORD_W-1:0]   payload_len,
    output logic [adb_pkg::STATUS_W-1:0] status,
    output logic                         last
);
    import adb_pkg::*;

    logic                  phase_reg,  phase_next;
    logic [HCOUNT_W-1:0]   hcount_reg, hcount_next;
    logic [WORD_W-1:0]     words_reg [HDR_WORDS];
    logic [WORD_W-1:0]     words_next [HDR_WORDS];
    logic [CAP_W-1:0]      pcount_reg, pcount_next;
    logic [WORD_W-1:0]     sum_reg,    sum_next;
    logic [SLICE_W-1:0]    slice_reg,  slice_next;
    logic [CAP_W-1:0]      cap_reg;
    logic [SLICE_W-1:0]    tmo_reg;

    logic                  out_valid_reg;
    logic                  kind_reg;
    logic [BYTE_W-1:0]     byte_reg;
    logic [WORD_W-1:0]     command_reg, arg_first_reg, arg_second_reg, length_reg;
    status_t               status_reg;

    logic                  accept;
    logic                  res_valid;
    logic                  res_kind;
    logic [BYTE_W-1:0]     res_byte;
    status_t               res_status;
    logic                  show_hdr;
    logic                  rearm;
    logic [2:0]            widx;
    logic [1:0]            lane;
    logic [SLICE_W-1:0]    slice_inc;
    logic [CAP_W-1:0]      pcount_inc;
    logic [WORD_W-1:0]     sum_inc;
    logic [WORD_W-1:0]     magic;
    hdr_result_t           chk;

    assign cfg_ready = 1'b1;
    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;

    assign widx       = hcount_reg[HCOUNT_W-1:2];
    assign lane       = hcount_reg[1:0];
    assign slice_inc  = slice_reg + SLICE_W'(1);
    assign pcount_inc = pcount_reg + CAP_W'(1);
    assign sum_inc    = sum_reg + {{(WORD_W-BYTE_W){1'b0}}, rx_byte};
    assign magic      = {rx_byte, words_reg[5][WORD_W-BYTE_W-1:0]};

    adb_hdr_check u_hdr_check (
        .command  (words_reg[0]),
        .length   (words_reg[3]),
        .check    (words_reg[4]),
        .magic    (magic),
        .capacity (cap_reg),
        .result   (chk)
    );

    always_comb
    begin
        phase_next  = phase_reg;
        hcount_next = hcount_reg;
        words_next  = words_reg;
        pcount_next = pcount_reg;
        sum_next    = sum_reg;
        slice_next  = slice_reg;
        res_valid   = 1'b0;
        res_kind    = 1'b0;
        res_byte    = '0;
        res_status  = ST_OK;
        show_hdr    = phase_reg;
        rearm       = 1'b0;
        if (accept)
        begin
            unique case (func_t'(func))
                FN_CLOSE:
                begin
                    res_valid  = 1'b1;
                    res_kind   = 1'b1;
                    res_status = ST_CLOSED;
                    rearm      = 1'b1;
                end
                FN_TICK:
                begin
                    if (slice_inc >= tmo_reg)
                    begin
                        res_valid  = 1'b1;
                        res_kind   = 1'b1;
                        res_status = ST_TIMEOUT;
                        rearm      = 1'b1;
                    end
                    else
                    begin
                        slice_next = slice_inc;
                    end
                end
                FN_BYTE:
                begin
                    if (!phase_reg)
                    begin
                        words_next[widx][{lane, 3'b000} +: BYTE_W] = rx_byte;
                        hcount_next = hcount_reg + HCOUNT_W'(1);
                        if (hcount_reg == HCOUNT_W'(HDR_BYTES - 1))
                        begin
                            show_hdr = 1'b1;
                            if (chk.go_payload)
                            begin
                                phase_next  = 1'b1;
                                hcount_next = '0;
                                pcount_next = '0;
                                sum_next    = '0;
                                slice_next  = '0;
                            end
                            else
                            begin
                                res_valid  = 1'b1;
                                res_kind   = 1'b1;
                                res_status = chk.status;
                                rearm      = 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        res_valid = 1'b1;
                        res_byte  = rx_byte;
                        if ({{(WORD_W-CAP_W){1'b0}}, pcount_inc} >= words_reg[3])
                        begin
                            res_kind   = 1'b1;
                            res_status = (sum_inc == words_reg[4]) ? ST_OK : ST_BAD_SUM;
                            rearm      = 1'b1;
                        end
                        else
                        begin
                            pcount_next = pcount_inc;
                            sum_next    = sum_inc;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
        if (rearm)
        begin
            phase_next  = 1'b0;
            hcount_next = '0;
            pcount_next = '0;
            sum_next    = '0;
            slice_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= 1'b0;
            hcount_reg    <= '0;
            pcount_reg    <= '0;
            sum_reg       <= '0;
            slice_reg     <= '0;
            cap_reg       <= CAP_RESET;
            tmo_reg       <= TIMEOUT_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            hcount_reg <= hcount_next;
            pcount_reg <= pcount_next;
            sum_reg    <= sum_next;
            slice_reg  <= slice_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_CAPACITY: cap_reg <= cfg_data[CAP_W-1:0];
                    REG_TIMEOUT:  tmo_reg <= cfg_data[SLICE_W-1:0];
                endcase
            end
            if (res_valid)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        words_reg <= words_next;
        if (res_valid)
        begin
            kind_reg       <= res_kind;
            byte_reg       <= res_byte;
            status_reg     <= res_status;
            command_reg    <= show_hdr ? words_reg[0] : '0;
            arg_first_reg  <= show_hdr ? words_reg[1] : '0;
            arg_second_reg <= show_hdr ? words_reg[2] : '0;
            length_reg     <= show_hdr ? words_reg[3] : '0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign kind        = kind_reg;
    assign data_byte   = byte_reg;
    assign command     = command_reg;
    assign arg_first   = arg_first_reg;
    assign arg_second  = arg_second_reg;
    assign payload_len = length_reg;
    assign status      = status_reg;
    assign last        = kind_reg;

endmodule

// File: rtl/adb_deframer_checker.sv
// ----------------------------------------------------------------------------
// adb_deframer_checker
// Port-level checks on the deframer's result channel, bound to the top level.
// ----------------------------------------------------------------------------
module adb_deframer_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic                         kind,
    input logic [adb_pkg::BYTE_W-1:0]   data_byte,
    input logic [adb_pkg::WORD_W-1:0]   payload_len,
    input logic [adb_pkg::STATUS_W-1:0] status,
    input logic                         last
);
    import adb_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(data_byte) && $stable(status)
            && $stable(kind))
        else $error("result changed while stalled");

    a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> last == kind)
        else $error("last does not mark the verdict");

    a_byte_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !kind |-> status == ST_OK && payload_len != '0)
        else $error("payload byte outside a valid message");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status == ST_OK || status == ST_BAD_MAGIC || status == ST_TOO_LONG
            || status == ST_BAD_SUM || status == ST_TIMEOUT || status == ST_CLOSED)
        else $error("status code out of range");

    a_early_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_BAD_MAGIC || status == ST_TOO_LONG) |-> data_byte == '0)
        else $error("header verdict carries a byte");

endmodule

bind adb_message_deframer_unit adb_deframer_checker u_adb_deframer_checker (.*);

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the ADB message deframer unit.
// Link events go in through a valid/ready port and an in-bench model of
// header assembly, payload pass-through and verdict rules predicts every
// output transaction, which is compared field by field in arrival order.
// Directed messages cover each verdict, the empty payload, capacity clamping
// and timeouts in both phases; random phases then mix well-formed messages
// with noise, broken framing, backpressure and a long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import adb_pkg::*;

    localparam logic [FUNC_W-1:0] FN_UNUSED   = 2'd3;
    localparam int                CYCLE_LIMIT = 1000000;

    typedef struct packed {
        logic                kind;
        logic [BYTE_W-1:0]   data_byte;
        logic [WORD_W-1:0]   command;
        logic [WORD_W-1:0]   arg_first;
        logic [WORD_W-1:0]   arg_second;
        logic [WORD_W-1:0]   payload_len;
        status_t             status;
        logic                last;
    } deframe_out_t;

    class message_tracker;
        deframe_out_t         pending_results[$];
        logic [CAP_W-1:0]     capacity;
        logic [SLICE_W-1:0]   slice_limit;
        bit                   in_payload;
        int                   hdr_count;
        logic [WORD_W-1:0]    words [HDR_WORDS];
        int                   pay_count;
        logic [WORD_W-1:0]    byte_sum;
        logic [SLICE_W-1:0]   slices;
        int                   errors;
        int                   events_in;
        int                   payload_bytes;
        int                   verdicts [6];

        function new();
            capacity    = CAP_RESET;
            slice_limit = TIMEOUT_RESET;
            rearm();
        endfunction

        function void rearm();
            in_payload = 1'b0;
            hdr_count  = 0;
            foreach (words[i])
                words[i] = '0;
            pay_count  = 0;
            byte_sum   = '0;
            slices     = '0;
        endfunction

        function bit at_header_start();
            return !in_payload && hdr_count == 0;
        endfunction

        function int effective_cap();
            return (capacity > MAX_PAYLOAD) ? int'(MAX_PAYLOAD) : int'(capacity);
        endfunction

        function void set_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            if (cfg_reg_t'(idx) == REG_CAPACITY)
                capacity = value[CAP_W-1:0];
            else
                slice_limit = value[SLICE_W-1:0];
        endfunction

        function void queue_result(logic k, logic [BYTE_W-1:0] b, status_t st);
            deframe_out_t r;
            r.kind        = k;
            r.data_byte   = b;
            r.command     = in_payload ? words[0] : '0;
            r.arg_first   = in_payload ? words[1] : '0;
            r.arg_second  = in_payload ? words[2] : '0;
            r.payload_len = in_payload ? words[3] : '0;
            r.status      = st;
            r.last        = k;
            pending_results.push_back(r);
            if (k)
                verdicts[st]++;
            else
                payload_bytes++;
        endfunction

        function void note_event(logic [FUNC_W-1:0] f, logic [BYTE_W-1:0] b);
            events_in++;
            if (f == FN_CLOSE)
            begin
                queue_result(1'b1, '0, ST_CLOSED);
                rearm();
            end
            else if (f == FN_TICK)
            begin
                slices = slices + 1'b1;
                if (slices >= slice_limit)
                begin
                    queue_result(1'b1, '0, ST_TIMEOUT);
                    rearm();
                end
            end
            else if (f == FN_BYTE && !in_payload)
            begin
                words[hdr_count / 4] |= 32'(b) << (8 * (hdr_count % 4));
                hdr_count++;
                if (hdr_count == HDR_BYTES)
                begin
                    in_payload = 1'b1;
                    if (words[5] != ~words[0])
                    begin
                        queue_result(1'b1, '0, ST_BAD_MAGIC);
                        rearm();
                    end
                    else if (words[3] > effective_cap())
                    begin
                        queue_result(1'b1, '0, ST_TOO_LONG);
                        rearm();
                    end
                    else if (words[3] == 0)
                    begin
                        queue_result(1'b1, '0, (words[4] == 0) ? ST_OK : ST_BAD_SUM);
                        rearm();
                    end
                    else
                    begin
                        pay_count = 0;
                        byte_sum  = '0;
                        slices    = '0;
                    end
                end
            end
            else if (f == FN_BYTE)
            begin
                byte_sum += b;
                pay_count++;
                if (pay_count >= words[3])
                begin
                    queue_result(1'b1, b, (byte_sum == words[4]) ? ST_OK : ST_BAD_SUM);
                    rearm();
                end
                else
                    queue_result(1'b0, b, ST_OK);
            end
        endfunction

        task report(string what, logic [WORD_W-1:0] got_v, logic [WORD_W-1:0] want_v);
            errors++;
            if (errors <= 40)
                $display("%0t ns: %s mismatch, got %0h, expected %0h", $time, what, got_v,
                         want_v);
        endtask

        task check_result(deframe_out_t got);
            deframe_out_t want;
            if (pending_results.size() == 0)
            begin
                report("unexpected transaction", WORD_W'(got.kind), '0);
                return;
            end
            want = pending_results.pop_front();
            if (got.kind != want.kind)
                report("kind", WORD_W'(got.kind), WORD_W'(want.kind));
            if (got.data_byte != want.data_byte)
                report("data_byte", WORD_W'(got.data_byte), WORD_W'(want.data_byte));
            if (got.command != want.command)
                report("command", got.command, want.command);
            if (got.arg_first != want.arg_first)
                report("arg_first", got.arg_first, want.arg_first);
            if (got.arg_second != want.arg_second)
                report("arg_second", got.arg_second, want.arg_second);
            if (got.payload_len != want.payload_len)
                report("payload_len", got.payload_len, want.payload_len);
            if (got.status != want.status)
                report("status", WORD_W'(got.status), WORD_W'(want.status));
            if (got.last != want.last)
                report("last", WORD_W'(got.last), WORD_W'(want.last));
        endtask
    endclass

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_INDEX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_data;
    logic                    in_valid;
    logic                    in_ready;
    logic [FUNC_W-1:0]       func;
    logic [BYTE_W-1:0]       rx_byte;
    logic                    out_valid;
    logic                    out_ready;
    logic                    kind;
    logic [BYTE_W-1:0]       data_byte;
    logic [WORD_W-1:0]       command;
    logic [WORD_W-1:0]       arg_first;
    logic [WORD_W-1:0]       arg_second;
    logic [WORD_W-1:0]       payload_len;
    logic [STATUS_W-1:0]     status;
    logic                    last;

    message_tracker sb;
    bit             idling   = 1'b1;
    bit             hold_off = 1'b0;
    int             cycle_count = 0;

    adb_message_deframer_unit DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .func        (func),
        .rx_byte     (rx_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .kind        (kind),
        .data_byte   (data_byte),
        .command     (command),
        .arg_first   (arg_first),
        .arg_second  (arg_second),
        .payload_len (payload_len),
        .status      (status),
        .last        (last)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        deframe_out_t got;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                got.kind        = kind;
                got.data_byte   = data_byte;
                got.command     = command;
                got.arg_first   = arg_first;
                got.arg_second  = arg_second;
                got.payload_len = payload_len;
                got.status      = status_t'(status);
                got.last        = last;
                sb.check_result(got);
            end
            if (in_valid && in_ready)
                sb.note_event(func, rx_byte);
            if (cfg_valid && cfg_ready)
                sb.set_register(cfg_index, cfg_data);
        end
    end

    initial
    begin
        int stall_left;
        out_ready  = 1'b0;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_off)
                out_ready <= 1'b0;
            else if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else if (idling && $urandom_range(0, 9) == 0)
            begin
                out_ready  <= 1'b0;
                stall_left = $urandom_range(0, 12);
            end
            else
                out_ready <= 1'b1;
        end
    end

    task automatic send_event(input logic [FUNC_W-1:0] f, input logic [BYTE_W-1:0] b);
        if (idling && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clk);
        end
        in_valid <= 1'b1;
        func     <= f;
        rx_byte  <= b;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending_results.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // cut >= 0 stops the message after that many bytes
    task automatic send_message(input logic [WORD_W-1:0] cmd, input logic [WORD_W-1:0] len,
                                input bit bad_magic, input bit bad_sum, input int noise,
                                input int cut);
        logic [WORD_W-1:0] hdr [HDR_WORDS];
        logic [BYTE_W-1:0] body [$];
        logic [WORD_W-1:0] total;
        int                n;
        int                stop;
        total = '0;
        n = (!bad_magic && len != 0 && len <= sb.effective_cap()) ? int'(len) : 0;
        for (int i = 0; i < n; i++)
        begin
            body.push_back(8'($urandom));
            total += body[i];
        end
        hdr[0] = cmd;
        hdr[1] = $urandom;
        hdr[2] = $urandom;
        hdr[3] = len;
        hdr[4] = bad_sum ? total ^ (32'h1 << $urandom_range(0, 31)) : total;
        hdr[5] = bad_magic ? ~cmd ^ (32'h1 << $urandom_range(0, 31)) : ~cmd;
        stop = (cut >= 0 && cut < HDR_BYTES + n) ? cut : HDR_BYTES + n;
        for (int i = 0; i < stop; i++)
        begin
            if ($urandom_range(0, 99) < noise)
            begin
                case ($urandom_range(0, 19))
                    0:       send_event(FN_CLOSE, 8'($urandom));
                    1, 2, 3: send_event(FN_UNUSED, 8'($urandom));
                    default: send_event(FN_TICK, 8'($urandom));
                endcase
            end
            send_event(FN_BYTE, (i < HDR_BYTES) ? hdr[i / 4][8 * (i % 4) +: 8]
                                                : body[i - HDR_BYTES]);
        end
    endtask

    task automatic random_phase(input int quota, input int noise);
        int                stop;
        int                sel;
        int                ecap;
        logic [WORD_W-1:0] len;
        stop = sb.events_in + quota;
        while (sb.events_in < stop)
        begin
            // realign on a header boundary
            if (!sb.at_header_start())
            begin
                if (sb.slice_limit <= 40 && $urandom_range(0, 1) == 0)
                    while (!sb.at_header_start()) send_event(FN_TICK, 8'($urandom));
                else
                    send_event(FN_CLOSE, 8'($urandom));
            end
            sel  = $urandom_range(0, 19);
            ecap = sb.effective_cap();
            if (sel == 0)
                repeat ($urandom_range(1, 24)) send_event(FN_TICK, 8'($urandom));
            else if (sel == 1)
            begin
                repeat ($urandom_range(1, 30))
                begin
                    if ($urandom_range(0, 3) == 0)
                        send_event(FN_UNUSED, 8'($urandom));
                    else
                        send_event(FN_BYTE, 8'($urandom));
                end
            end
            else
            begin
                case ($urandom_range(0, 39))
                    0:             len = $urandom_range(0, (ecap < 600) ? ecap : 600);
                    1, 2, 3, 4:    len = 0;
                    5, 6, 7:       len = ecap + 1 + $urandom_range(0, 40);
                    8, 9:          len = $urandom;
                    default:       len = $urandom_range((ecap < 1) ? 0 : 1,
                                                        (ecap < 8) ? ecap : 8);
                endcase
                send_message($urandom, len, $urandom_range(0, 9) == 0,
                             $urandom_range(0, 5) == 0, noise,
                             (sel == 2) ? int'($urandom_range(1, 30)) : -1);
            end
        end
    endtask

    initial
    begin
        sb        = new();
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        func      = FN_BYTE;
        rx_byte   = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_CAPACITY;
        cfg_data  = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_message(32'h0, 0, 1'b0, 1'b0, 0, -1);
        send_message(32'hFFFF_FFFF, 1, 1'b0, 1'b0, 0, -1);
        send_message($urandom, 5, 1'b0, 1'b1, 0, -1);
        send_message($urandom, 0, 1'b0, 1'b1, 0, -1);
        send_message($urandom, 7, 1'b1, 1'b0, 0, -1);
        send_message($urandom, 4097, 1'b0, 1'b0, 0, -1);
        send_message($urandom, 32'hFFFF_FFFF, 1'b1, 1'b0, 0, -1);
        send_message($urandom, 32'hFFFF_FFFF, 1'b0, 1'b0, 0, -1);
        send_message($urandom, 4, 1'b0, 1'b0, 0, 9);
        send_event(FN_CLOSE, 8'hFF);
        send_message($urandom, 6, 1'b0, 1'b0, 0, 26);
        send_event(FN_CLOSE, 8'h00);
        send_message($urandom, 3, 1'b0, 1'b0, 0, 10);
        send_event(FN_UNUSED, 8'hA5);
        send_event(FN_CLOSE, 8'h5A);
        send_event(FN_UNUSED, 8'hFF);

        write_reg(REG_TIMEOUT, 3);
        repeat (3) send_event(FN_TICK, 8'h00);
        repeat (2) send_event(FN_TICK, 8'hFF);
        send_message($urandom, 2, 1'b0, 1'b0, 0, HDR_BYTES);
        repeat (2) send_event(FN_TICK, 8'h00);
        send_message($urandom, 2, 1'b0, 1'b0, 0, -1);
        send_message($urandom, 10, 1'b0, 1'b0, 0, HDR_BYTES + 4);
        repeat (3) send_event(FN_TICK, 8'h00);
        write_reg(REG_TIMEOUT, 0);
        send_event(FN_TICK, 8'h00);

        write_reg(REG_CAPACITY, 8191);
        write_reg(REG_TIMEOUT, 65535);
        send_message($urandom, 4096, 1'b0, 1'b0, 0, HDR_BYTES + 6);
        send_event(FN_CLOSE, 8'h00);
        send_message($urandom, 4097, 1'b0, 1'b0, 0, -1);
        write_reg(REG_CAPACITY, 0);
        send_message($urandom, 0, 1'b0, 1'b0, 0, -1);
        send_message($urandom, 1, 1'b0, 1'b0, 0, -1);

        write_reg(REG_CAPACITY, 64);
        write_reg(REG_TIMEOUT, 8);
        random_phase(140, 6);
        write_reg(REG_TIMEOUT, 1);
        write_reg(REG_CAPACITY, 0);
        random_phase(120, 2);
        write_reg(REG_CAPACITY, 4096);
        write_reg(REG_TIMEOUT, 65535);
        fork
            begin
                hold_off = 1'b1;
                repeat (400) @(posedge clk);
                hold_off = 1'b0;
            end
        join_none
        random_phase(150, 4);
        write_reg(REG_CAPACITY, 8191);
        write_reg(REG_TIMEOUT, 20);
        random_phase(150, 5);
        drain();
        idling = 1'b0;
        write_reg(REG_CAPACITY, 300);
        write_reg(REG_TIMEOUT, 12);
        random_phase(150, 5);
        drain();

        $display("Covered %0d link events and %0d passed payload bytes over several %s",
                 sb.events_in, sb.payload_bytes, "register settings.");
        $display("Verdicts: ok %0d, bad magic %0d, too long %0d, bad sum %0d, %s %0d, %s %0d",
                 sb.verdicts[ST_OK], sb.verdicts[ST_BAD_MAGIC], sb.verdicts[ST_TOO_LONG],
                 sb.verdicts[ST_BAD_SUM], "timeout", sb.verdicts[ST_TIMEOUT],
                 "closed", sb.verdicts[ST_CLOSED]);
        if (sb.errors == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
